// File: src/assert_macros.svh
// assertion macros used by the stencil top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define STC3_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define STC3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/stc3_pkg.sv
// types and constants of the seven-point 3d stencil
package stc3_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COORD_W    = 6;
    localparam int GS_W       = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
    localparam int SAT_MAX    = 32767;
    localparam int SAT_MIN    = -32768;
    localparam int GS_MIN     = 3;

    localparam logic [GS_W-1:0]     GS_RESET   = 7'd64;
    localparam logic [COEF_W-1:0]   COEF_RESET = 16'd8192;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LEFT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_RIGHT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_DOWN   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_UP     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BEHIND = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_AHEAD  = 4'd7;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    // neighbour values read from the plane stores
    typedef struct packed {
        t_sample center;
        t_sample left;
        t_sample right;
        t_sample down;
        t_sample up;
        t_sample behind;
    } t_stc_taps;

    typedef struct packed {
        t_coef center;
        t_coef left;
        t_coef right;
        t_coef down;
        t_coef up;
        t_coef behind;
        t_coef ahead;
    } t_stc_coefs;

    // position and boundary flag travelling with a result
    typedef struct packed {
        logic               interior;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_stc_meta;

endpackage

// File: src/stc3_if.sv
// stream and configuration channels of the stencil
interface stc3_in_if;
    import stc3_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface stc3_out_if;
    import stc3_pkg::*;
    logic               valid;
    logic               ready;
    t_sample            result;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_z;

    modport source (output valid, output result, output out_x, output out_y, output out_z,
                    input ready);
    modport sink (input valid, input result, input out_x, input out_y, input out_z,
                  output ready);
endinterface

interface stc3_cfg_if;
    import stc3_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/stc3_ram.sv
// generic ram, one write port, two registered read ports, read-first
module stc3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: src/stc3_store.sv
// ping-pong plane store, three copies giving six neighbour reads a cycle
module stc3_store import stc3_pkg::*; #(
    parameter int CW = 6
) (
    input  logic          i_clk,
    input  logic          i_req,
    input  logic          i_prev_bank,
    input  logic [CW-1:0] i_x,
    input  logic [CW-1:0] i_y,
    input  t_sample       i_wdata,
    output t_stc_taps     o_taps
);

    localparam int AW    = 2 * CW + 1;
    localparam int DEPTH = 2 ** AW;

    logic [CW-1:0] x_m1, x_p1, y_m1, y_p1;
    logic [AW-1:0] a_center, a_left, a_right, a_down, a_up, a_own;
    logic [SAMPLE_W-1:0] rd_center, rd_left, rd_right, rd_down, rd_up, rd_behind;

    assign x_m1 = i_x - CW'(1);
    assign x_p1 = i_x + CW'(1);
    assign y_m1 = i_y - CW'(1);
    assign y_p1 = i_y + CW'(1);

    // bank bit on top, then row, then column
    assign a_center = {i_prev_bank, i_y, i_x};
    assign a_left   = {i_prev_bank, i_y, x_m1};
    assign a_right  = {i_prev_bank, i_y, x_p1};
    assign a_down   = {i_prev_bank, y_p1, i_x};
    assign a_up     = {i_prev_bank, y_m1, i_x};
    assign a_own    = {~i_prev_bank, i_y, i_x};

    // older plane is read and overwritten at the same entry: read-first
    stc3_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_copy0 (
        .i_clk     (i_clk),
        .i_we      (i_req),
        .i_waddr   (a_own),
        .i_wdata   (i_wdata),
        .i_re      (i_req),
        .i_raddr_a (a_center),
        .i_raddr_b (a_own),
        .o_rdata_a (rd_center),
        .o_rdata_b (rd_behind)
    );

    stc3_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_copy1 (
        .i_clk     (i_clk),
        .i_we      (i_req),
        .i_waddr   (a_own),
        .i_wdata   (i_wdata),
        .i_re      (i_req),
        .i_raddr_a (a_left),
        .i_raddr_b (a_right),
        .o_rdata_a (rd_left),
        .o_rdata_b (rd_right)
    );

    stc3_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_copy2 (
        .i_clk     (i_clk),
        .i_we      (i_req),
        .i_waddr   (a_own),
        .i_wdata   (i_wdata),
        .i_re      (i_req),
        .i_raddr_a (a_down),
        .i_raddr_b (a_up),
        .o_rdata_a (rd_down),
        .o_rdata_b (rd_up)
    );

    assign o_taps.center = rd_center;
    assign o_taps.left   = rd_left;
    assign o_taps.right  = rd_right;
    assign o_taps.down   = rd_down;
    assign o_taps.up     = rd_up;
    assign o_taps.behind = rd_behind;

endmodule

// File: src/stc3_arith.sv
// weighting pipeline: products, pair sums, final sum with rounding and saturation
module stc3_arith import stc3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_stc_taps  i_taps,
    input  t_sample    i_sample,
    input  t_stc_meta  i_meta,
    input  t_stc_coefs i_coefs,
    output logic       o_valid,
    input  logic       i_ready,
    output t_sample    o_result,
    output t_stc_meta  o_meta
);

    logic en_p, en_s, en_o;

    logic                     r_vp, r_vs, r_vo;
    logic signed [PROD_W-1:0] n_prod [7];
    logic signed [PROD_W-1:0] r_prod [7];
    logic signed [PAIR_W-1:0] n_pair [4];
    logic signed [PAIR_W-1:0] r_pair [4];
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  n_q;
    t_sample                  n_result;
    t_sample                  r_result;
    t_stc_meta                r_meta_p, r_meta_s, r_meta_o;

    // each stage moves when the next one is empty or moving
    assign en_o    = !r_vo || i_ready;
    assign en_s    = !r_vs || en_o;
    assign en_p    = !r_vp || en_s;
    assign o_ready = en_p;

    assign n_prod[0] = i_coefs.center * i_taps.center;
    assign n_prod[1] = i_coefs.left * i_taps.left;
    assign n_prod[2] = i_coefs.right * i_taps.right;
    assign n_prod[3] = i_coefs.down * i_taps.down;
    assign n_prod[4] = i_coefs.up * i_taps.up;
    assign n_prod[5] = i_coefs.behind * i_taps.behind;
    assign n_prod[6] = i_coefs.ahead * i_sample;

    assign n_pair[0] = PAIR_W'(r_prod[0]) + PAIR_W'(r_prod[1]);
    assign n_pair[1] = PAIR_W'(r_prod[2]) + PAIR_W'(r_prod[3]);
    assign n_pair[2] = PAIR_W'(r_prod[4]) + PAIR_W'(r_prod[5]);
    assign n_pair[3] = PAIR_W'(r_prod[6]);

    // round half up, floor by arithmetic shift, then clamp; boundary points give zero
    always_comb begin
        n_acc = ACC_W'(r_pair[0]) + ACC_W'(r_pair[1]) + ACC_W'(r_pair[2])
              + ACC_W'(r_pair[3]) + ACC_W'(ROUND_BIAS);
        n_q   = n_acc >>> FRAC_SHIFT;
        if (n_q > ACC_W'(SAT_MAX)) begin
            n_result = SAMPLE_W'(SAT_MAX);
        end else if (n_q < ACC_W'(SAT_MIN)) begin
            n_result = SAMPLE_W'(SAT_MIN);
        end else begin
            n_result = n_q[SAMPLE_W-1:0];
        end
        if (!r_meta_s.interior) begin
            n_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vs <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_p) begin
                r_vp <= i_valid;
            end
            if (en_s) begin
                r_vs <= r_vp;
            end
            if (en_o) begin
                r_vo <= r_vs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_prod   <= n_prod;
            r_meta_p <= i_meta;
        end
        if (en_s) begin
            r_pair   <= n_pair;
            r_meta_s <= r_meta_p;
        end
        if (en_o) begin
            r_result <= n_result;
            r_meta_o <= r_meta_s;
        end
    end

    assign o_valid  = r_vo;
    assign o_result = r_result;
    assign o_meta   = r_meta_o;

endmodule

// File: src/stencil_3d_seven_point_top.sv
// top level of the seven-point 3d stencil
`include "assert_macros.svh"

// Seven-point 3D stencil over a cubic grid of edge N (grid_size, clamped to
// 3..GRID_MAX) streamed in raster order, x fastest. One sample per clock is
// sustained while the output is not stalled; a sample of plane z gives the
// result for the same column and row of plane z-1 through the store read,
// product, pair-sum and output registers, and plane 0 gives none. The rate
// is set by the plane store: two banks of GRID_MAX*GRID_MAX entries, held in
// three identical copies of a two-read-port ram, so the five in-plane
// neighbours of plane z-1 and the entry of plane z-2 are read together in the
// request cycle while the new sample overwrites that plane z-2 entry. The
// store needs no clearing after reset and the block is ready at once.
// Arithmetic runs in three registered stages (seven 16x16 products, pair
// sums, final sum with round half up and saturation to Q8.8). Configuration
// writes are always taken and must only be made while no request is in flight.
module stencil_3d_seven_point_top import stc3_pkg::*; #(
    parameter int GRID_MAX = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    stc3_cfg_if.sink i_cfg,
    stc3_in_if.sink  i_in,
    stc3_out_if.source o_out
);

    // coordinate width, and a width that holds both grid_size and GRID_MAX
    localparam int CW = $clog2(GRID_MAX);
    localparam int NW = (CW + 1 > GS_W) ? CW + 1 : GS_W;

    // configuration registers
    logic [GS_W-1:0] r_grid_size;
    t_stc_coefs      r_coefs;

    // raster position of the next sample and the bank holding plane z-1
    logic [CW-1:0] r_x, r_y, r_z;
    logic [CW-1:0] n_x, n_y, n_z;
    logic          r_plane_sel, n_plane_sel;

    // request stage, lined up with the registered ram read
    logic      r_s1_valid;
    t_stc_meta r_s1_meta;
    t_sample   r_s1_sample;

    logic          w_accept;
    logic          w_en1;
    logic          w_arith_ready;
    logic [NW-1:0] w_gs, w_n;
    logic [NW-1:0] w_x, w_y, w_z, w_pz;
    logic          w_last_x, w_last_y, w_last_z;
    logic          w_emit, w_interior;
    t_stc_meta     w_meta;
    t_stc_taps     w_taps;
    logic          w_out_valid;
    t_sample       w_out_result;
    t_stc_meta     w_out_meta;

    // configuration port, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size    <= GS_RESET;
            r_coefs.center <= COEF_RESET;
            r_coefs.left   <= COEF_RESET;
            r_coefs.right  <= COEF_RESET;
            r_coefs.down   <= COEF_RESET;
            r_coefs.up     <= COEF_RESET;
            r_coefs.behind <= COEF_RESET;
            r_coefs.ahead  <= COEF_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_GRID_SIZE:   r_grid_size    <= i_cfg.data[GS_W-1:0];
                CFG_COEF_CENTER: r_coefs.center <= i_cfg.data;
                CFG_COEF_LEFT:   r_coefs.left   <= i_cfg.data;
                CFG_COEF_RIGHT:  r_coefs.right  <= i_cfg.data;
                CFG_COEF_DOWN:   r_coefs.down   <= i_cfg.data;
                CFG_COEF_UP:     r_coefs.up     <= i_cfg.data;
                CFG_COEF_BEHIND: r_coefs.behind <= i_cfg.data;
                CFG_COEF_AHEAD:  r_coefs.ahead  <= i_cfg.data;
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // effective edge length, grid_size clamped to the supported range
    assign w_gs = NW'(r_grid_size);
    always_comb begin
        if (w_gs < NW'(GS_MIN)) begin
            w_n = NW'(GS_MIN);
        end else if (w_gs > NW'(GRID_MAX)) begin
            w_n = NW'(GRID_MAX);
        end else begin
            w_n = w_gs;
        end
    end

    // a request enters when the request stage is empty or moving on
    assign w_en1      = !r_s1_valid || w_arith_ready;
    assign i_in.ready = w_en1;
    assign w_accept   = i_in.valid && w_en1;

    assign w_x  = NW'(r_x);
    assign w_y  = NW'(r_y);
    assign w_z  = NW'(r_z);
    assign w_pz = w_z - NW'(1);

    // a counter at or past the last position wraps on the next sample
    assign w_last_x = (w_x + NW'(1)) >= w_n;
    assign w_last_y = (w_y + NW'(1)) >= w_n;
    assign w_last_z = (w_z + NW'(1)) >= w_n;

    assign w_emit     = (r_z != '0);
    assign w_interior = (w_x >= NW'(1)) && (w_x + NW'(2) <= w_n)
                     && (w_y >= NW'(1)) && (w_y + NW'(2) <= w_n)
                     && (w_pz >= NW'(1)) && (w_pz + NW'(2) <= w_n);

    assign w_meta.interior = w_interior;
    assign w_meta.x        = COORD_W'(r_x);
    assign w_meta.y        = COORD_W'(r_y);
    assign w_meta.z        = COORD_W'(w_pz);

    always_comb begin
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_plane_sel = r_plane_sel;
        if (w_accept) begin
            if (w_last_x) begin
                n_x = '0;
                if (w_last_y) begin
                    // end of plane: the bank just written becomes plane z-1
                    n_y         = '0;
                    n_plane_sel = ~r_plane_sel;
                    n_z         = w_last_z ? '0 : r_z + CW'(1);
                end else begin
                    n_y = r_y + CW'(1);
                end
            end else begin
                n_x = r_x + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_z         <= '0;
            r_plane_sel <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
            r_plane_sel <= n_plane_sel;
            if (w_en1) begin
                // plane 0 samples only fill the store
                r_s1_valid <= w_accept && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_meta   <= w_meta;
            r_s1_sample <= i_in.sample;
        end
    end

    // plane store: neighbour reads and the write of the new sample
    stc3_store #(.CW(CW)) u_store (
        .i_clk       (i_clk),
        .i_req       (w_accept),
        .i_prev_bank (r_plane_sel),
        .i_x         (r_x),
        .i_y         (r_y),
        .i_wdata     (i_in.sample),
        .o_taps      (w_taps)
    );

    // weighting, rounding and saturation, ending in the output register
    stc3_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .o_ready  (w_arith_ready),
        .i_taps   (w_taps),
        .i_sample (r_s1_sample),
        .i_meta   (r_s1_meta),
        .i_coefs  (r_coefs),
        .o_valid  (w_out_valid),
        .i_ready  (o_out.ready),
        .o_result (w_out_result),
        .o_meta   (w_out_meta)
    );

    assign o_out.valid  = w_out_valid;
    assign o_out.result = w_out_result;
    assign o_out.out_x  = w_out_meta.x;
    assign o_out.out_y  = w_out_meta.y;
    assign o_out.out_z  = w_out_meta.z;

    // a stalled request stage keeps its item
    `STC3_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_arith_ready, r_s1_valid && $stable(r_s1_meta), "request stage lost its item")
    // an empty output register never blocks a request
    `STC3_ASSERT(a_ready_free, i_clk, i_rst_n, !o_out.valid |-> i_in.ready, "input stalled with output register empty")
    // boundary points give zero
    `STC3_ASSERT(a_boundary_zero, i_clk, i_rst_n, o_out.valid && !w_out_meta.interior |-> o_out.result == '0, "boundary result not zero")
    // the banks swap at the end of every plane
    `STC3_ASSERT_NEXT(a_bank_swap, i_clk, i_rst_n, w_accept && w_last_x && w_last_y, r_plane_sel != $past(r_plane_sel), "plane banks did not swap")

endmodule

// File: tb/stencil_3d_seven_point_top_tb.sv
// self-checking testbench for the seven-point 3d stencil top level
`timescale 1ns / 1ps

module stencil_3d_seven_point_top_tb;
    import stc3_pkg::*;

    // plane store geometry, kept equal to the block's parameter
    localparam int GRID_LIMIT  = 64;
    localparam int PLANE_WORDS = GRID_LIMIT * GRID_LIMIT;

    // run shape
    localparam int RANDOM_ITEMS   = 1150;
    localparam int SETTLE_CYCLES  = 12;    // idle margin after the last output
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, pressure phase
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all

    // weights at the ends of the Q2.14 range
    localparam t_coef COEF_TOP    = 16'sh7FFF;
    localparam t_coef COEF_BOTTOM = 16'sh8000;
    localparam t_coef COEF_PLUS1  = 16'sh4000;
    localparam t_coef COEF_MINUS1 = 16'shC000;

    // index beyond the register file, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 4'd12;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum int {CM_RANDOM, CM_TOP, CM_BOTTOM, CM_EXTREMES, CM_HALF} t_coef_mode;

    // one expected stencil output
    typedef struct {
        t_sample            value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_point_result;

    // clock, reset and everything driven into the block start at known values
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_sample               in_sample = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    stc3_cfg_if cfg_ch();
    stc3_in_if  in_ch();
    stc3_out_if out_ch();

    assign cfg_ch.valid  = cfg_valid;
    assign cfg_ch.index  = cfg_index;
    assign cfg_ch.data   = cfg_data;
    assign in_ch.valid   = in_valid;
    assign in_ch.sample  = in_sample;
    assign out_ch.ready  = out_ready;

    stencil_3d_seven_point_top #(
        .GRID_MAX (GRID_LIMIT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the block: registers, ping-pong plane store, raster position
    // ------------------------------------------------------------------
    logic [GS_W-1:0] grid_reg  = GS_RESET;
    t_stc_coefs      coef_regs = '{default: COEF_RESET};
    t_sample         plane_mem [0:2*PLANE_WORDS-1];
    int unsigned     col_pos   = 0;
    int unsigned     row_pos   = 0;
    int unsigned     plane_pos = 0;
    bit              bank_sel  = 1'b0;   // bank holding plane z-1

    t_point_result   expected_points [$];
    t_sample         sample_queue [$];

    int unsigned items_queued    = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned interior_seen   = 0;
    int unsigned saturated_seen  = 0;
    int unsigned settings_used   = 0;
    int unsigned error_count     = 0;

    t_idle_mode  idle_mode    = IDLE_NONE;
    bit          pressure_arm = 1'b0;
    bit          in_taken     = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // grid_size saturated into the supported range
    function automatic int unsigned effective_edge();
        int unsigned n;
        n = 32'(grid_reg);
        if (n < GS_MIN) n = GS_MIN;
        if (n > GRID_LIMIT) n = GRID_LIMIT;
        return n;
    endfunction

    function automatic int unsigned store_addr(input bit bank, input int unsigned x,
                                               input int unsigned y);
        return bank * PLANE_WORDS + (y % GRID_LIMIT) * GRID_LIMIT + (x % GRID_LIMIT);
    endfunction

    function automatic longint tap(input bit bank, input int unsigned x, input int unsigned y);
        return longint'(plane_mem[store_addr(bank, x, y)]);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_GRID_SIZE:   grid_reg = value[GS_W-1:0];
            CFG_COEF_CENTER: coef_regs.center = value;
            CFG_COEF_LEFT:   coef_regs.left = value;
            CFG_COEF_RIGHT:  coef_regs.right = value;
            CFG_COEF_DOWN:   coef_regs.down = value;
            CFG_COEF_UP:     coef_regs.up = value;
            CFG_COEF_BEHIND: coef_regs.behind = value;
            CFG_COEF_AHEAD:  coef_regs.ahead = value;
            default: ;
        endcase
    endfunction

    // one accepted sample: expected output for plane z-1, store update, step
    function automatic void advance_stencil(input t_sample s);
        int unsigned   n, x, y, z;
        bit            prev_bank, old_bank, interior;
        longint        acc;
        t_point_result pt;
        n = effective_edge();
        x = col_pos;
        y = row_pos;
        z = plane_pos;
        prev_bank = bank_sel;
        old_bank  = !bank_sel;
        if (z >= 1) begin
            // interior of plane z-1, i.e. z-1 in 1..n-2
            interior = x >= 1 && x + 2 <= n && y >= 1 && y + 2 <= n &&
                       z >= 2 && z + 1 <= n;
            pt.value = '0;
            if (interior) begin
                acc = longint'($signed(coef_regs.center)) * tap(prev_bank, x, y)
                    + longint'($signed(coef_regs.left))   * tap(prev_bank, x - 1, y)
                    + longint'($signed(coef_regs.right))  * tap(prev_bank, x + 1, y)
                    + longint'($signed(coef_regs.down))   * tap(prev_bank, x, y + 1)
                    + longint'($signed(coef_regs.up))     * tap(prev_bank, x, y - 1)
                    + longint'($signed(coef_regs.behind)) * tap(old_bank, x, y)
                    + longint'($signed(coef_regs.ahead))  * longint'(s);
                // round half up into Q8.8, then clip
                acc = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
                if (acc > SAT_MAX) begin
                    acc = SAT_MAX;
                    saturated_seen++;
                end else if (acc < SAT_MIN) begin
                    acc = SAT_MIN;
                    saturated_seen++;
                end
                pt.value = t_sample'(acc);
                interior_seen++;
            end
            pt.x = COORD_W'(x);
            pt.y = COORD_W'(y);
            pt.z = COORD_W'(z - 1);
            expected_points.push_back(pt);
        end
        // the arriving sample replaces the plane z-2 entry just read
        plane_mem[store_addr(old_bank, x, y)] = s;
        if (x + 1 >= n) begin
            col_pos = 0;
            if (y + 1 >= n) begin
                row_pos   = 0;
                bank_sel  = old_bank;
                plane_pos = (z + 1 >= n) ? 0 : z + 1;
            end else begin
                row_pos = y + 1;
            end
        end else begin
            col_pos = x + 1;
        end
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input int want);
        if (got !== want)
            report_mismatch($sformatf("output %0d field %s: got %0d, expected %0d",
                                      results_checked, name, got, want));
    endtask

    task automatic check_result();
        t_point_result want;
        if (expected_points.size() == 0) begin
            report_mismatch($sformatf("unexpected output %0d at (%0d,%0d,%0d)",
                                      out_ch.result, out_ch.out_x, out_ch.out_y,
                                      out_ch.out_z));
            return;
        end
        want = expected_points.pop_front();
        check_field("result", out_ch.result, int'(want.value));
        check_field("out_x", out_ch.out_x, int'(want.x));
        check_field("out_y", out_ch.out_y, int'(want.y));
        check_field("out_z", out_ch.out_z, int'(want.z));
        results_checked++;
    endtask

    // random idling, per side, for the current phase
    function automatic bit idle_roll(input bit sending);
        int unsigned pct;
        case (idle_mode)
            IDLE_SEND: pct = sending ? 56 : 0;
            IDLE_RECV: pct = sending ? 0 : 56;
            IDLE_BOTH: pct = 20;
            default:   pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // sample driver: holds a request until it is taken, gaps at random
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (sample_queue.size() != 0 && !idle_roll(1'b1)) begin
                in_valid  <= 1'b1;
                in_sample <= sample_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output side ready: random stalls, and one long hold-off on request
    // ------------------------------------------------------------------
    bit          pressure_done = 1'b0;
    int unsigned hold_left     = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (pressure_arm && !pressure_done) begin
            // the sender keeps going, so the pipeline fills and back-pressures
            pressure_done = 1'b1;
            hold_left     = HOLD_CYCLES;
            out_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= !idle_roll(1'b0);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each accepted request, check each accepted output
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                advance_stencil(in_ch.sample);
                items_accepted++;
            end
            if (out_ch.valid && out_ch.ready)
                check_result();
        end
    end

    // watchdog on handshake activity of any channel
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no handshake for %0d cycles", $realtime,
                         quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, value);
    endtask

    task automatic cfg_release();
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // grid size word with junk in the unused upper bits
    function automatic logic [CFG_DATA_W-1:0] grid_word(input int unsigned edge_len);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom());
        w[GS_W-1:0] = edge_len[GS_W-1:0];
        return w;
    endfunction

    function automatic t_coef pick_coef(input t_coef_mode mode);
        case (mode)
            CM_TOP:    return COEF_TOP;
            CM_BOTTOM: return COEF_BOTTOM;
            CM_HALF:   return COEF_RESET;
            CM_EXTREMES: begin
                case ($urandom_range(4))
                    0:       return COEF_TOP;
                    1:       return COEF_BOTTOM;
                    2:       return COEF_PLUS1;
                    3:       return COEF_MINUS1;
                    default: return '0;
                endcase
            end
            default:   return t_coef'($urandom());
        endcase
    endfunction

    task automatic load_coefs(input t_coef_mode mode);
        cfg_write(CFG_COEF_CENTER, pick_coef(mode));
        cfg_write(CFG_COEF_LEFT, pick_coef(mode));
        cfg_write(CFG_COEF_RIGHT, pick_coef(mode));
        cfg_write(CFG_COEF_DOWN, pick_coef(mode));
        cfg_write(CFG_COEF_UP, pick_coef(mode));
        cfg_write(CFG_COEF_BEHIND, pick_coef(mode));
        cfg_write(CFG_COEF_AHEAD, pick_coef(mode));
    endtask

    // field extremes are weighted up so that saturation shows up often
    function automatic t_sample pick_sample();
        case ($urandom_range(7))
            0:       return t_sample'(SAT_MAX);
            1:       return t_sample'(SAT_MIN);
            2:       return t_sample'($urandom_range(2)) - 1;
            default: return t_sample'($urandom());
        endcase
    endfunction

    task automatic queue_sample(input t_sample s);
        sample_queue.push_back(s);
        items_queued++;
    endtask

    // wait for every request taken and every output seen, then let it settle
    task automatic drain();
        while (items_accepted != items_queued || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned edge_len, phase_idx, random_items, grids, pick;
        t_coef_mode  mode;
        foreach (plane_mem[i]) plane_mem[i] = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest grid, top weights; the seven taps of the only
        // interior point sit at full scale so the sum clips high, the rest of
        // the grid walks through the extremes of the sample range
        idle_mode = IDLE_NONE;
        cfg_write(CFG_GRID_SIZE, grid_word(GS_MIN));
        load_coefs(CM_TOP);
        cfg_release();
        for (int i = 0; i < GS_MIN * GS_MIN * GS_MIN; i++) begin
            if (i == 4 || i == 10 || i == 12 || i == 13 || i == 14 || i == 16 || i == 22)
                queue_sample(t_sample'(SAT_MAX));
            else begin
                case (i % 5)
                    0:       queue_sample(t_sample'(SAT_MIN));
                    1:       queue_sample('0);
                    2:       queue_sample(-16'sd1);
                    3:       queue_sample(16'sd1);
                    default: queue_sample(t_sample'(SAT_MAX));
                endcase
            end
        end
        drain();

        // largest grid, requested above the supported edge so it clamps;
        // two full rows of plane 0 check the column wrap at the clamped edge,
        // then the edge drops to the minimum mid-grid, which leaves the row
        // counter on the last row so it wraps after that row, and the grid is run out to its end
        idle_mode = IDLE_BOTH;
        cfg_write(CFG_GRID_SIZE, grid_word(127));
        load_coefs(CM_RANDOM);
        cfg_release();
        repeat (2 * GRID_LIMIT) queue_sample(pick_sample());
        drain();
        cfg_write(CFG_GRID_SIZE, grid_word(GS_MIN));
        cfg_release();
        repeat (GS_MIN + 2 * GS_MIN * GS_MIN) queue_sample(pick_sample());
        drain();

        // random phases of whole grids, one setting and idling mode each
        phase_idx    = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            idle_mode = t_idle_mode'(phase_idx % 4);
            if (phase_idx == 0) begin
                edge_len = 6;   // big enough to fill the pipe under the hold-off
            end else begin
                pick = $urandom_range(99);
                if (pick < 10)      edge_len = $urandom_range(2);  // clamps up to 3
                else if (pick < 40) edge_len = GS_MIN;
                else if (pick < 70) edge_len = $urandom_range(5, 4);
                else if (pick < 92) edge_len = $urandom_range(8, 6);
                else                edge_len = 9;
            end
            mode = t_coef_mode'($urandom_range(4));
            cfg_write(CFG_GRID_SIZE, grid_word(edge_len));
            load_coefs(mode);
            if (phase_idx == 1)
                cfg_write(CFG_SPARE_INDEX, CFG_DATA_W'($urandom()));
            cfg_release();
            if (phase_idx == 0)
                pressure_arm = 1'b1;
            edge_len = effective_edge();
            grids    = $urandom_range(3, 1);
            // keep the total close to the planned item count
            while (grids > 1 &&
                   random_items + grids * edge_len * edge_len * edge_len > RANDOM_ITEMS)
                grids--;
            repeat (grids * edge_len * edge_len * edge_len) queue_sample(pick_sample());
            random_items += grids * edge_len * edge_len * edge_len;
            drain();
            phase_idx++;
        end

        if (expected_points.size() != 0)
            report_mismatch($sformatf("%0d expected outputs never arrived",
                                      expected_points.size()));

        $display("covered %0d samples over %0d register settings, edges 3 to 64, %0d phases",
                 items_queued, settings_used, phase_idx + 2);
        $display("checked %0d outputs: %0d interior, %0d clipped, %0d mismatches",
                 results_checked, interior_seen, saturated_seen, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
